// ===== src/tlcrc_pkg.sv =====
`timescale 1ns / 1ps

package tlcrc_pkg;

    localparam int unsigned LANES = 3;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // CRC-8 polynomial x^8 + x^2 + x + 1, MSB first
    localparam logic [7:0] CRC_POLY = 8'h07;

    // lane pointer codes
    localparam logic [1:0] LANE_0   = 2'd0;
    localparam logic [1:0] LANE_1   = 2'd1;
    localparam logic [1:0] LANE_2   = 2'd2;
    localparam logic [1:0] LANE_BAD = 2'd3;

    typedef struct packed {
        logic [LANES-1:0][7:0] lane;
        logic [1:0]            ptr;
    } t_state;

endpackage

// ===== src/tlcrc_update.sv =====
`timescale 1ns / 1ps

// Next-state and packed result for one beat.
module tlcrc_update (
    input  tlcrc_pkg::t_state i_state,
    input  logic              i_command,
    input  logic [31:0]       i_seed,
    input  logic [7:0]        i_data_byte,
    output tlcrc_pkg::t_state o_state,
    output logic [31:0]       o_word
);

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ tlcrc_pkg::CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    logic [1:0] pos;
    logic [7:0] sel_lane;
    logic [7:0] upd_lane;

    always_comb begin
        unique case (i_state.ptr)
            tlcrc_pkg::LANE_1: sel_lane = i_state.lane[1];
            tlcrc_pkg::LANE_2: sel_lane = i_state.lane[2];
            default:           sel_lane = i_state.lane[0];
        endcase
    end

    assign upd_lane = crc8_step(sel_lane, i_data_byte);
    assign pos      = i_seed[25:24];

    always_comb begin
        o_state = i_state;
        if (i_command == tlcrc_pkg::CMD_LOAD) begin
            o_state.lane[0] = i_seed[7:0];
            o_state.lane[1] = i_seed[15:8];
            o_state.lane[2] = i_seed[23:16];
            // reserve/version bits dropped; position 3 folds to 0
            o_state.ptr     = (pos == tlcrc_pkg::LANE_BAD) ? tlcrc_pkg::LANE_0 : pos;
        end else begin
            unique case (i_state.ptr)
                tlcrc_pkg::LANE_1: begin
                    o_state.lane[1] = upd_lane;
                    o_state.ptr     = tlcrc_pkg::LANE_2;
                end
                tlcrc_pkg::LANE_2: begin
                    o_state.lane[2] = upd_lane;
                    o_state.ptr     = tlcrc_pkg::LANE_0;
                end
                default: begin
                    o_state.lane[0] = upd_lane;
                    o_state.ptr     = tlcrc_pkg::LANE_1;
                end
            endcase
        end
    end

    assign o_word = {6'd0, o_state.ptr, o_state.lane[2], o_state.lane[1], o_state.lane[0]};

endmodule

// ===== src/three_lane_crc8_engine.sv =====
`timescale 1ns / 1ps

// Three interleaved CRC-8 lanes (poly 0x07, MSB first) with a round-robin
// lane pointer. A load beat (command 0) sets the lanes from seed bytes 0-2
// and the pointer from seed bits 25:24 (3 reads as 0; bits 31:26 ignored).
// A data beat (command 1) folds data_byte into the pointed lane and moves
// the pointer on, 0 -> 1 -> 2 -> 0. Every beat yields one result: the
// packed word (lane0 7:0, lane1 15:8, lane2 23:16, pointer 25:24, rest
// zero) and block_done, the echo of final_byte on data beats and 0 on
// loads. Throughput is one beat per clock while the downstream accepts;
// a result appears in the cycle after its input beat, held in a single
// output register. The input is ready whenever that register is empty or
// being drained in the same cycle, so ready follows the downstream ready
// combinationally. Reset clears all lanes and the pointer.
module three_lane_crc8_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_seed,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_crc_word,
    output logic        o_block_done
);

    tlcrc_pkg::t_state r_state;
    tlcrc_pkg::t_state n_state;
    logic [31:0]       n_word;
    logic              r_out_valid;
    logic [31:0]       r_word;
    logic              r_done;
    logic              in_fire;

    // output slot free now, or being emptied this edge
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    tlcrc_update u_update (
        .i_state     (r_state),
        .i_command   (i_command),
        .i_seed      (i_seed),
        .i_data_byte (i_data_byte),
        .o_state     (n_state),
        .o_word      (n_word)
    );

    // lane state and result valid: control, reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= n_word;
            r_done <= (i_command == tlcrc_pkg::CMD_DATA) ? i_final_byte : 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_crc_word   = r_word;
    assign o_block_done = r_done;

endmodule

// ===== src/tlcrc_checker.sv =====
`timescale 1ns / 1ps

module tlcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_command,
    input logic [31:0] i_seed,
    input logic        i_final_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_crc_word,
    input logic        o_block_done
);

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_crc_word)
                                           && $stable(o_block_done)))
        else $error("result changed while stalled");

    // packed word: pointer never 3, top bits clear
    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_crc_word[25:24] != tlcrc_pkg::LANE_BAD
                         && o_crc_word[31:26] == 6'd0))
        else $error("malformed packed word");

    // load beat returns its seed lanes, not done
    a_load_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_command == tlcrc_pkg::CMD_LOAD) |=> (o_out_valid && !o_block_done
            && o_crc_word[23:0] == $past(i_seed[23:0])))
        else $error("load result wrong");

    // data beat echoes final_byte
    a_done_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_command == tlcrc_pkg::CMD_DATA) |=> (o_out_valid
            && o_block_done == $past(i_final_byte)))
        else $error("block_done not echoed");

endmodule

bind three_lane_crc8_engine tlcrc_checker u_tlcrc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_command    (i_command),
    .i_seed       (i_seed),
    .i_final_byte (i_final_byte),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_crc_word   (o_crc_word),
    .o_block_done (o_block_done)
);

// ===== bench/three_lane_crc8_checker.sv =====
`timescale 1ns / 1ps

module three_lane_crc8_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_seed,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_crc_word,
    input  logic        i_block_done,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [31:0] word;
        logic        done;
    } t_crc_result;

    tlcrc_pkg::t_state lane_state;
    t_crc_result       expected_words[$];

    // one CRC-8 step, MSB first, on (crc ^ byte)
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] v;
        v = crc ^ d;
        for (int b = 0; b < 8; b++)
            v = v[7] ? ((v << 1) ^ tlcrc_pkg::CRC_POLY) : (v << 1);
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_crc_result want;
        logic [1:0]  idx;
        logic [1:0]  pos;
        if (!i_rst_n) begin
            lane_state = '0;
            expected_words.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            // result side first: a result never leaves in its own input cycle
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result: crc_word %08h block_done %0b",
                             $time, i_crc_word, i_block_done);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    o_checked++;
                    if (i_crc_word !== want.word) begin
                        $display("%0t: crc_word mismatch: expected %08h, got %08h",
                                 $time, want.word, i_crc_word);
                        o_fail_count++;
                    end
                    if (i_block_done !== want.done) begin
                        $display("%0t: block_done mismatch: expected %0b, got %0b",
                                 $time, want.done, i_block_done);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want.done = 1'b0;
                if (i_command == tlcrc_pkg::CMD_LOAD) begin
                    // top byte cleaned: only the position survives, 3 reads as 0
                    pos = i_seed[25:24];
                    lane_state.lane[0] = i_seed[7:0];
                    lane_state.lane[1] = i_seed[15:8];
                    lane_state.lane[2] = i_seed[23:16];
                    lane_state.ptr = (pos == tlcrc_pkg::LANE_BAD) ? tlcrc_pkg::LANE_0 : pos;
                end else begin
                    idx = (lane_state.ptr == tlcrc_pkg::LANE_BAD) ? tlcrc_pkg::LANE_0
                                                                  : lane_state.ptr;
                    lane_state.lane[idx] = crc8_fold(lane_state.lane[idx], i_data_byte);
                    lane_state.ptr = (idx == tlcrc_pkg::LANE_2) ? tlcrc_pkg::LANE_0
                                                                : idx + 2'd1;
                    want.done = i_final_byte;
                end
                want.word = {6'b0, lane_state.ptr, lane_state.lane[2],
                             lane_state.lane[1], lane_state.lane[0]};
                expected_words.push_back(want);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== bench/three_lane_crc8_engine_tb.sv =====
`timescale 1ns / 1ps

module three_lane_crc8_engine_tb;

    // quiet cycles (no beat on either channel) before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PER_PHASE = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = tlcrc_pkg::CMD_LOAD;
    logic [31:0] seed = 32'h0;
    logic [7:0]  data_byte = 8'h0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] crc_word;
    logic        block_done;

    int fail_count;
    int pending;
    int checked;

    // percentages: sender idle per cycle, receiver stall per cycle
    int idle_pct = 0;
    int stall_pct = 0;

    int sent_beats = 0;
    int sent_loads = 0;
    int sent_bytes = 0;
    int sent_ends = 0;
    int quiet_cycles = 0;

    // per-phase idling: none, sender only, receiver only, both
    int phase_idle[4] = '{0, 48, 0, 15};
    int phase_stall[4] = '{0, 0, 48, 15};

    always #5 clk = ~clk;

    three_lane_crc8_engine i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_command    (command),
        .i_seed       (seed),
        .i_data_byte  (data_byte),
        .i_final_byte (final_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_crc_word   (crc_word),
        .o_block_done (block_done)
    );

    three_lane_crc8_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_command    (command),
        .i_seed       (seed),
        .i_data_byte  (data_byte),
        .i_final_byte (final_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_crc_word   (crc_word),
        .i_block_done (block_done),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Receiver: ready redrawn every falling edge; stall_pct of cycles held off.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one input beat. Entered and left just after a falling edge, so
    // valid gets a single update per step and stays high until the beat goes.
    task automatic push_crc_beat(input logic cmd, input logic [31:0] s,
                                 input logic [7:0] d, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        seed       <= s;
        data_byte  <= d;
        final_byte <= fin;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
        sent_beats++;
        if (cmd == tlcrc_pkg::CMD_LOAD)
            sent_loads++;
        else begin
            sent_bytes++;
            if (fin)
                sent_ends++;
        end
    endtask

    // Mostly well-formed buffers: optional seed load, then a run of bytes with
    // the end flag on the last one. The rest is noise: lone beats, any fields.
    task automatic run_random_buffers(input int target);
        int issued;
        int len;
        issued = 0;
        while (issued < target) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(99) < 70) begin
                    push_crc_beat(tlcrc_pkg::CMD_LOAD, $urandom, $urandom_range(255),
                                  $urandom_range(1));
                    issued++;
                end
                // the odd long buffer so the pointer wraps many times over
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 13)
                                                : $urandom_range(12, 1);
                for (int k = 0; k < len; k++)
                    push_crc_beat(tlcrc_pkg::CMD_DATA, $urandom, $urandom_range(255),
                                  k == len - 1);
                issued += len;
            end else begin
                push_crc_beat($urandom_range(1), $urandom, $urandom_range(255),
                              $urandom_range(1));
                issued++;
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: lanes straight after reset, pointer walking 0-1-2 and
        // wrapping, extreme bytes, end flag both ways.
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'hffff_ffff, 8'hff, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h80, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h01, 1'b1);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'hff, 1'b1);
        // all-ones seed: reserve and version bits set, position 3 folds to lane 0;
        // end flag on a load must not come through
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'hffff_ffff, 8'hff, 1'b1);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'ha5, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'h0000_0000, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'hff, 1'b1);
        // positions 1 and 2, with and without junk in the top bits
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'h01ab_cdef, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h5a, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'hfe00_ff00, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h3c, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'hc3, 1'b1);
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'h0200_0000, 8'h00, 1'b1);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h00, 1'b0);
        // top bytes with positions 3 and 0 under different reserve/version patterns
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'he312_3456, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h7f, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'h1f80_8080, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h80, 1'b1);
        push_crc_beat(tlcrc_pkg::CMD_LOAD, 32'hfc00_0000, 8'h00, 1'b0);
        push_crc_beat(tlcrc_pkg::CMD_DATA, 32'h0, 8'h01, 1'b1);

        // Random buffers through each idling phase.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            run_random_buffers(RANDOM_PER_PHASE);
        end

        // Drain: every expected result in, then a short tail for strays.
        in_valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);

        $display("Sent %0d beats: %0d seed loads, %0d data bytes, %0d buffer ends",
                 sent_beats, sent_loads, sent_bytes, sent_ends);
        $display("Checked %0d results over four idling phases, %0d errors",
                 checked, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/tlcrc_pkg.sv
src/tlcrc_update.sv
src/three_lane_crc8_engine.sv
src/tlcrc_checker.sv
bench/three_lane_crc8_checker.sv
bench/three_lane_crc8_engine_tb.sv
